@@ hdl/htfd_pkg.sv @@
// Package with the shared constants, codes, types and CRC function of the frame decoder.
`default_nettype none

package htfd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [2:0] POS_TEMP_HI = 3'd0;
  localparam logic [2:0] POS_TEMP_LO = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_HI = 3'd3;
  localparam logic [2:0] POS_HUM_LO = 3'd4;
  localparam logic [2:0] POS_HUM_CRC = 3'd5;
  localparam logic [2:0] POS_MAX = 3'd7;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_WRONG_LEN = 2'd1;
  localparam logic [1:0] ST_TEMP_CRC = 2'd2;
  localparam logic [1:0] ST_HUM_CRC = 2'd3;

  localparam logic [14:0] TEMP_SPAN = 15'd17500;
  localparam logic signed [14:0] TEMP_OFFSET = 15'sd4500;
  localparam logic [13:0] HUM_SPAN = 14'd10000;

  typedef struct packed {
    logic [1:0] status;
    logic [15:0] temp_word;
    logic [15:0] hum_word;
  } frame_info_t;

  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [13:0] hum_centi;
  } scaled_t;

  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hdl/htfd_byte_if.sv @@
// Interface for the channel that carries received frame bytes.
`default_nettype none

interface htfd_byte_if;
  logic valid;
  logic ready;
  logic [7:0] rx_byte;
  logic frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

`default_nettype wire

@@ hdl/htfd_result_if.sv @@
// Interface for the channel that carries decoded measurement results.
`default_nettype none

interface htfd_result_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic signed [14:0] temp_centi;
  logic [13:0] hum_centi;
  logic [15:0] temp_raw;
  logic [15:0] hum_raw;

  modport source (output valid, output status, output temp_centi, output hum_centi,
                  output temp_raw, output hum_raw, input ready);
  modport sink (input valid, input status, input temp_centi, input hum_centi,
                input temp_raw, input hum_raw, output ready);
endinterface

`default_nettype wire

@@ hdl/htfd_frame_track.sv @@
// Frame state: byte position, running CRC, word assembly and status decision.
`default_nettype none

module htfd_frame_track (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  wire logic [7:0] rx_byte,
  input  wire logic frame_end,
  output htfd_pkg::frame_info_t info
);

  logic [2:0] pos;
  logic [2:0] pos_next;
  logic [7:0] crc;
  logic [7:0] crc_next;
  logic [15:0] temp_word;
  logic [15:0] temp_word_next;
  logic [15:0] hum_word;
  logic [15:0] hum_word_next;
  logic temp_good;
  logic temp_good_next;
  logic hum_good;
  logic [7:0] crc_fed;

  assign crc_fed = htfd_pkg::crc8_feed(crc, rx_byte);

  always_comb begin
    crc_next = crc;
    temp_word_next = temp_word;
    hum_word_next = hum_word;
    temp_good_next = temp_good;
    hum_good = 1'b0;
    case (pos)
      htfd_pkg::POS_TEMP_HI: begin
        temp_word_next = {rx_byte, 8'h00};
        crc_next = crc_fed;
      end
      htfd_pkg::POS_TEMP_LO: begin
        temp_word_next = {temp_word[15:8], temp_word[7:0] | rx_byte};
        crc_next = crc_fed;
      end
      htfd_pkg::POS_TEMP_CRC: begin
        temp_good_next = (crc == rx_byte);
        crc_next = htfd_pkg::CRC_INIT;
      end
      htfd_pkg::POS_HUM_HI: begin
        hum_word_next = {rx_byte, 8'h00};
        crc_next = crc_fed;
      end
      htfd_pkg::POS_HUM_LO: begin
        hum_word_next = {hum_word[15:8], hum_word[7:0] | rx_byte};
        crc_next = crc_fed;
      end
      htfd_pkg::POS_HUM_CRC: begin
        hum_good = (crc == rx_byte);
      end
      default: begin
      end
    endcase
    pos_next = (pos == htfd_pkg::POS_MAX) ? pos : pos + 3'd1;
  end

  always_comb begin
    if (pos != htfd_pkg::POS_HUM_CRC) begin
      info.status = htfd_pkg::ST_WRONG_LEN;
    end else if (!temp_good) begin
      info.status = htfd_pkg::ST_TEMP_CRC;
    end else if (!hum_good) begin
      info.status = htfd_pkg::ST_HUM_CRC;
    end else begin
      info.status = htfd_pkg::ST_OK;
    end
    info.temp_word = temp_word_next;
    info.hum_word = hum_word_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && frame_end)) begin
      pos <= '0;
      crc <= htfd_pkg::CRC_INIT;
      temp_word <= '0;
      hum_word <= '0;
      temp_good <= 1'b0;
    end else if (step) begin
      pos <= pos_next;
      crc <= crc_next;
      temp_word <= temp_word_next;
      hum_word <= hum_word_next;
      temp_good <= temp_good_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/htfd_scale.sv @@
// Conversion of the raw words to hundredths of a degree and of percent humidity, zero on an error status.
`default_nettype none

module htfd_scale (
  input  wire htfd_pkg::frame_info_t info,
  output htfd_pkg::scaled_t scaled
);

  // x / 65535 is (x + (x >> 16) + 1) >> 16 for any x below 2^32 - 1.
  logic [30:0] temp_prod;
  logic [31:0] temp_sum;
  logic [14:0] temp_q;
  logic [29:0] hum_prod;
  logic [30:0] hum_sum;
  logic [13:0] hum_q;
  logic signed [14:0] temp_val;

  assign temp_prod = 31'(htfd_pkg::TEMP_SPAN) * 31'(info.temp_word);
  assign temp_sum = 32'(temp_prod) + 32'(temp_prod[30:16]) + 32'd1;
  assign temp_q = temp_sum[30:16];
  assign temp_val = $signed(temp_q) - htfd_pkg::TEMP_OFFSET;

  assign hum_prod = 30'(htfd_pkg::HUM_SPAN) * 30'(info.hum_word);
  assign hum_sum = 31'(hum_prod) + 31'(hum_prod[29:16]) + 31'd1;
  assign hum_q = hum_sum[29:16];

  always_comb begin
    if (info.status == htfd_pkg::ST_OK) begin
      scaled.temp_centi = temp_val;
      scaled.hum_centi = hum_q;
    end else begin
      scaled.temp_centi = '0;
      scaled.hum_centi = '0;
    end
  end

endmodule

`default_nettype wire

@@ hdl/humidity_temp_frame_decoder_unit.sv @@
// Top level of the humidity and temperature measurement frame decoder.
// Every byte item is registered at acceptance and processed from that register.
// A result is registered when the frame's last byte leaves the input register.
// One byte item can be accepted in every cycle; only a waiting result stalls input.
// Synchronous reset empties the input and result registers and restarts the frame.
`default_nettype none

module humidity_temp_frame_decoder_unit (
  input wire logic clk,
  input wire logic rst,
  htfd_byte_if.sink rx,
  htfd_result_if.source meas
);

  logic s1_valid;
  logic [7:0] s1_byte;
  logic s1_end;
  logic s1_advance;
  logic res_load;
  logic res_valid;
  htfd_pkg::frame_info_t info;
  htfd_pkg::scaled_t scaled;

  assign s1_advance = s1_valid && (!s1_end || !res_valid || meas.ready);
  assign res_load = s1_advance && s1_end;
  assign rx.ready = !s1_valid || s1_advance;

  htfd_frame_track u_track (
    .clk(clk),
    .rst(rst),
    .step(s1_advance),
    .rx_byte(s1_byte),
    .frame_end(s1_end),
    .info(info)
  );

  htfd_scale u_scale (
    .info(info),
    .scaled(scaled)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
      s1_end <= rx.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_load || (res_valid && !meas.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      meas.status <= info.status;
      meas.temp_centi <= scaled.temp_centi;
      meas.hum_centi <= scaled.hum_centi;
      meas.temp_raw <= info.temp_word;
      meas.hum_raw <= info.hum_word;
    end
  end

  assign meas.valid = res_valid;

  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (meas.valid && meas.status != htfd_pkg::ST_OK) |->
      (meas.temp_centi == 15'sd0 && meas.hum_centi == 14'd0))
    else $error("converted fields not zero on an error status");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    (meas.valid && meas.status == htfd_pkg::ST_OK) |-> (meas.hum_centi <= 14'd10000))
    else $error("humidity beyond full scale");

  a_stall_end: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_end && meas.valid && !meas.ready) |-> !rx.ready)
    else $error("input taken while a finished frame cannot be delivered");

  a_load_end: assert property (@(posedge clk) disable iff (rst)
    (meas.valid && !$past(meas.valid)) |-> $past(s1_valid && s1_end))
    else $error("result raised without a frame end");

endmodule

`default_nettype wire
